/* sv/xeu_pkg.sv */
// ----------------------------------------------------------------------------
// xeu_pkg
// types, trie codes and lookup functions shared by the entity unescaper
// ----------------------------------------------------------------------------
package xeu_pkg;

    localparam int POSITION_BITS_DEFAULT = 16;
    localparam int OUT_POSITION_W        = 16;
    localparam int QUEUE_DEPTH           = 4;

    typedef logic [3:0] node_t;
    typedef logic [2:0] len_t;
    typedef logic [0:4][7:0] text_t;

    // trie nodes, one per held prefix of an entity
    localparam node_t NODE_ROOT  = 4'd0;
    localparam node_t NODE_AMP   = 4'd1;
    localparam node_t NODE_Q     = 4'd2;
    localparam node_t NODE_QU    = 4'd3;
    localparam node_t NODE_QUO   = 4'd4;
    localparam node_t NODE_QUOT  = 4'd5;
    localparam node_t NODE_A     = 4'd6;
    localparam node_t NODE_AP    = 4'd7;
    localparam node_t NODE_APO   = 4'd8;
    localparam node_t NODE_APOS  = 4'd9;
    localparam node_t NODE_AM    = 4'd10;
    localparam node_t NODE_AMPP  = 4'd11;
    localparam node_t NODE_L     = 4'd12;
    localparam node_t NODE_LT    = 4'd13;
    localparam node_t NODE_G     = 4'd14;
    localparam node_t NODE_GT    = 4'd15;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } in_payload_t;

    typedef struct packed {
        logic [7:0]                out_byte;
        logic                      run_end;
        logic                      stream_end;
        logic [OUT_POSITION_W-1:0] out_position;
    } out_payload_t;

    // output work for one input transaction: held prefix, one byte, held tail
    typedef struct packed {
        node_t      prefix_node;
        logic       has_char;
        logic [7:0] char_byte;
        node_t      tail_node;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_slot_t;

    typedef struct packed {
        logic  hit;
        node_t node;
    } step_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] chr;
    } repl_t;

    function automatic step_t next_node(node_t node, logic [7:0] b);
        step_t s;
        s.hit  = 1'b1;
        s.node = NODE_ROOT;
        unique case (node)
            NODE_ROOT: if (b == "&") s.node = NODE_AMP; else s.hit = 1'b0;
            NODE_AMP:
            begin
                if (b == "q")      s.node = NODE_Q;
                else if (b == "a") s.node = NODE_A;
                else if (b == "l") s.node = NODE_L;
                else if (b == "g") s.node = NODE_G;
                else               s.hit  = 1'b0;
            end
            NODE_Q:   if (b == "u") s.node = NODE_QU;   else s.hit = 1'b0;
            NODE_QU:  if (b == "o") s.node = NODE_QUO;  else s.hit = 1'b0;
            NODE_QUO: if (b == "t") s.node = NODE_QUOT; else s.hit = 1'b0;
            NODE_A:
            begin
                if (b == "p")      s.node = NODE_AP;
                else if (b == "m") s.node = NODE_AM;
                else               s.hit  = 1'b0;
            end
            NODE_AP:  if (b == "o") s.node = NODE_APO;  else s.hit = 1'b0;
            NODE_APO: if (b == "s") s.node = NODE_APOS; else s.hit = 1'b0;
            NODE_AM:  if (b == "p") s.node = NODE_AMPP; else s.hit = 1'b0;
            NODE_L:   if (b == "t") s.node = NODE_LT;   else s.hit = 1'b0;
            NODE_G:   if (b == "t") s.node = NODE_GT;   else s.hit = 1'b0;
            default:  s.hit = 1'b0;
        endcase
        return s;
    endfunction

    function automatic repl_t completion(node_t node, logic [7:0] b);
        repl_t r;
        r.hit = (b == ";");
        r.chr = 8'h00;
        unique case (node)
            NODE_QUOT: r.chr = "\"";
            NODE_APOS: r.chr = "'";
            NODE_AMPP: r.chr = "&";
            NODE_LT:   r.chr = "<";
            NODE_GT:   r.chr = ">";
            default:   r.hit = 1'b0;
        endcase
        return r;
    endfunction

    function automatic len_t node_len(node_t node);
        len_t n;
        unique case (node)
            NODE_ROOT:                              n = 3'd0;
            NODE_AMP:                               n = 3'd1;
            NODE_Q, NODE_A, NODE_L, NODE_G:         n = 3'd2;
            NODE_QU, NODE_AP, NODE_AM, NODE_LT,
            NODE_GT:                                n = 3'd3;
            NODE_QUO, NODE_APO, NODE_AMPP:          n = 3'd4;
            default:                                n = 3'd5;
        endcase
        return n;
    endfunction

    function automatic text_t node_text(node_t node);
        text_t t;
        unique case (node)
            NODE_ROOT: t = '0;
            NODE_AMP:  t = {"&",     32'h0};
            NODE_Q:    t = {"&q",    24'h0};
            NODE_QU:   t = {"&qu",   16'h0};
            NODE_QUO:  t = {"&quo",   8'h0};
            NODE_QUOT: t = "&quot";
            NODE_A:    t = {"&a",    24'h0};
            NODE_AP:   t = {"&ap",   16'h0};
            NODE_APO:  t = {"&apo",   8'h0};
            NODE_APOS: t = "&apos";
            NODE_AM:   t = {"&am",   16'h0};
            NODE_AMPP: t = {"&amp",   8'h0};
            NODE_L:    t = {"&l",    24'h0};
            NODE_LT:   t = {"&lt",   16'h0};
            NODE_G:    t = {"&g",    24'h0};
            default:   t = {"&gt",   16'h0};
        endcase
        return t;
    endfunction

endpackage

/* sv/xeu_stream_if.sv */
// ----------------------------------------------------------------------------
// xeu_stream_if
// valid/ready channel carrying one payload per transaction
// ----------------------------------------------------------------------------
interface xeu_stream_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* sv/xml_entity_unescaper.sv */
// ----------------------------------------------------------------------------
// xml_entity_unescaper
// decodes the five predefined xml entities in a byte stream
// ----------------------------------------------------------------------------
// usage
// - escaped: one text byte per transaction (in_byte), is_last marks the
//   final byte of a string; matching never crosses a string boundary
// - unescaped: one decoded byte per transaction with its saturating
//   position in the output string; run_end flags the last byte caused by
//   an input transaction, stream_end the last byte of the string
// - an input byte that extends a partial entity yields no output; a full
//   entity yields one byte; a broken match or end of string flushes the
//   held prefix, so one input may yield up to six bytes
// - path: the input transaction is written into the work queue, and its
//   first output byte is then written into the output register
// - throughput: one input per cycle while the work queue has room; the
//   back end emits one output byte per cycle while unescaped is ready,
//   and the queue absorbs the burst of a flush
// - reset clears the match state, the work queue and the position counter
// - a stall on unescaped holds the output register; the queue then fills
//   and escaped.ready drops until space frees up
// ----------------------------------------------------------------------------
module xml_entity_unescaper #(
    parameter int POSITION_BITS = xeu_pkg::POSITION_BITS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    xeu_stream_if.sink   escaped,
    xeu_stream_if.source unescaped
);
    import xeu_pkg::*;

    // front to queue and queue to back work slots
    cmd_slot_t push;
    cmd_slot_t head;
    logic      q_full;
    logic      pop;

    // front: match tracking and work classification
    xeu_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .escaped (escaped),
        .q_full  (q_full),
        .push    (push)
    );

    // queue: decouples the byte-per-cycle front from flush bursts
    xeu_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .pop   (pop),
        .head  (head)
    );

    // back: byte expansion, positions and output register
    xeu_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .unescaped (unescaped)
    );

endmodule

/* sv/xeu_front.sv */
// ----------------------------------------------------------------------------
// xeu_front
// accepts text bytes, tracks the entity match and queues output work
// ----------------------------------------------------------------------------
module xeu_front (
    input  logic               clk,
    input  logic               rst_n,
    xeu_stream_if.sink         escaped,
    input  logic               q_full,
    output xeu_pkg::cmd_slot_t push
);
    import xeu_pkg::*;

    node_t      match_node_reg;
    node_t      match_node_next;
    cmd_t       cmd;
    step_t      step;
    repl_t      repl;
    logic       accept;
    logic [7:0] b;

    assign escaped.ready = !q_full;
    assign accept        = escaped.valid && escaped.ready;
    assign b             = escaped.payload.in_byte;

    always_comb
    begin
        step            = next_node(match_node_reg, b);
        repl            = completion(match_node_reg, b);
        cmd.prefix_node = NODE_ROOT;
        cmd.has_char    = 1'b0;
        cmd.char_byte   = b;
        cmd.tail_node   = NODE_ROOT;
        cmd.last        = escaped.payload.is_last;
        match_node_next = NODE_ROOT;
        if (repl.hit)
        begin
            cmd.has_char  = 1'b1;
            cmd.char_byte = repl.chr;
        end
        else if (step.hit)
        begin
            match_node_next = step.node;
        end
        else
        begin
            // broken match: flush held text, restart on the breaking byte
            cmd.prefix_node = match_node_reg;
            if (b == "&")
                match_node_next = NODE_AMP;
            else
                cmd.has_char = 1'b1;
        end
        if (escaped.payload.is_last)
        begin
            cmd.tail_node   = match_node_next;
            match_node_next = NODE_ROOT;
        end
    end

    assign push.cmd   = cmd;
    assign push.valid = accept && (cmd.prefix_node != NODE_ROOT || cmd.has_char
                                   || cmd.tail_node != NODE_ROOT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_node_reg <= NODE_ROOT;
        else if (accept)
            match_node_reg <= match_node_next;
    end

`ifndef SYNTH
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && escaped.payload.is_last |=> match_node_reg == NODE_ROOT)
        else $error("match held across end of string");
    a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && escaped.payload.is_last |-> push.valid)
        else $error("end of string produced no output work");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !q_full)
        else $error("push into full queue");
`endif

endmodule

/* sv/xeu_queue.sv */
// ----------------------------------------------------------------------------
// xeu_queue
// short fifo of output work between front and back
// ----------------------------------------------------------------------------
module xeu_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  xeu_pkg::cmd_slot_t push,
    output logic               full,
    input  logic               pop,
    output xeu_pkg::cmd_slot_t head
);
    import xeu_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = mem[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push.cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= PTR_W'(wr_ptr_reg + 1'b1);
            if (do_pop)
                rd_ptr_reg <= PTR_W'(rd_ptr_reg + 1'b1);
            if (do_push && !do_pop)
                count_reg <= CNT_W'(count_reg + 1'b1);
            else if (do_pop && !do_push)
                count_reg <= CNT_W'(count_reg - 1'b1);
        end
    end

`ifndef SYNTH
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid && !pop |=> head.valid)
        else $error("pushed entry lost");
`endif

endmodule

/* sv/xeu_back.sv */
// ----------------------------------------------------------------------------
// xeu_back
// expands queued work into output bytes, one per cycle unless unescaped stalls, with positions
// ----------------------------------------------------------------------------
module xeu_back #(
    parameter int POSITION_BITS = xeu_pkg::POSITION_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  xeu_pkg::cmd_slot_t head,
    output logic               pop,
    xeu_stream_if.source       unescaped
);
    import xeu_pkg::*;

    localparam int WIDE_W = POSITION_BITS + OUT_POSITION_W;

    len_t                     k_reg;
    len_t                     k_next;
    logic [POSITION_BITS-1:0] count_reg;
    logic [POSITION_BITS-1:0] count_next;
    logic                     out_valid_reg;
    out_payload_t             out_reg;
    out_payload_t             out_next;
    len_t                     len_p;
    len_t                     len_t_n;
    len_t                     total;
    len_t                     tail_idx;
    text_t                    text_pre;
    text_t                    text_tail;
    logic [7:0]               cur_byte;
    logic                     is_end;
    logic                     load;
    logic [WIDE_W-1:0]        pos_wide;

    assign len_p     = node_len(head.cmd.prefix_node);
    assign len_t_n   = node_len(head.cmd.tail_node);
    assign text_pre  = node_text(head.cmd.prefix_node);
    assign text_tail = node_text(head.cmd.tail_node);
    assign total     = len_t'(len_p + {2'b0, head.cmd.has_char} + len_t_n);
    assign tail_idx  = len_t'(k_reg - len_p - {2'b0, head.cmd.has_char});
    assign is_end    = (k_reg == len_t'(total - 1'b1));
    assign load      = head.valid && (!out_valid_reg || unescaped.ready);
    assign pop       = load && is_end;
    assign pos_wide  = {{OUT_POSITION_W{1'b0}}, count_reg};

    always_comb
    begin
        if (k_reg < len_p)
            cur_byte = text_pre[k_reg];
        else if (head.cmd.has_char && k_reg == len_p)
            cur_byte = head.cmd.char_byte;
        else
            cur_byte = text_tail[tail_idx];
    end

    always_comb
    begin
        out_next.out_byte     = cur_byte;
        out_next.run_end      = is_end;
        out_next.stream_end   = is_end && head.cmd.last;
        out_next.out_position = pos_wide[OUT_POSITION_W-1:0];
        k_next                = is_end ? '0 : len_t'(k_reg + 1'b1);
        if (out_next.stream_end)
            count_next = '0;
        else if (count_reg != '1)
            count_next = POSITION_BITS'(count_reg + 1'b1);
        else
            count_next = count_reg;
    end

    assign unescaped.valid   = out_valid_reg;
    assign unescaped.payload = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                k_reg         <= k_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (unescaped.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= out_next;
    end

`ifndef SYNTH
    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        head.valid |-> k_reg < total)
        else $error("byte index past end of queued work");
    a_stream_end_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.stream_end |-> out_reg.run_end)
        else $error("stream end without run end");
    a_position_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        load && out_next.stream_end |=> count_reg == '0)
        else $error("position not restarted after string");
`endif

endmodule
